// File: rtl/oale_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oale_pkg
// Shared types and constants for the ordered array list engine.
// ----------------------------------------------------------------------------
package oale_pkg;

  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam logic [6:0]  CAP_RESET     = 7'd64;

  typedef enum logic [2:0] {
    MODE_INSERT  = 3'd0,
    MODE_REMOVE  = 3'd1,
    MODE_READ    = 3'd2,
    MODE_SEARCH  = 3'd3,
    MODE_REPLACE = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    STATUS_OK       = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_EMPTY    = 3'd2,
    STATUS_BADPOS   = 3'd3,
    STATUS_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHUP,
    S_SHDN,
    S_RDWT,
    S_SRCH,
    S_WRV,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [6:0]         position;
    logic signed [31:0] data_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         found_position;
    logic [6:0]         entry_count;
    logic               is_empty;
    logic               is_full;
  } rsp_t;

endpackage

// File: rtl/ordered_array_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_engine_top
// Ordered list of signed 32-bit words held in one RAM, with insert, remove,
// read, search and replace requests and a capacity register.
//
//   channel | direction | beat
//   in      | in        | in_data_i  (mode, position, data_value)
//   out     | out       | out_data_o (status, read_value, found_position,
//           |           |             entry_count, is_empty, is_full)
//   cfg     | in        | cfg_data_i (capacity_limit)
//
// insert and remove shift the words behind the position, and search reads
// until a hit or the last word, one word per cycle; read and replace touch
// a single word, and a rejected or unused request touches none. the single
// read and single write port of the list RAM set this pace.
// reset clears the word count and sets the capacity to 64; RAM contents are
// not cleared. a finished result waits in the output register while the
// next request is taken; a stalled output holds the sequencer at its end.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_top #(
  parameter int unsigned DEPTH = oale_pkg::DEPTH_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  oale_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output oale_pkg::rsp_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [6:0]     cfg_data_i
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 7) ? CW : 7;

  logic [6:0]    cap_q, cap_d;
  logic [CW-1:0] cap_eff;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  assign cfg_ready_o = 1'b1;
  assign cap_d       = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : cap_q;

  // clamp capacity to 1..DEPTH
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (CMPW'(cap_q) > CMPW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= oale_pkg::CAP_RESET;
    end else begin
      cap_q <= cap_d;
    end
  end

  oale_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cap_i      (cap_eff),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  oale_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

// File: rtl/oale_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oale_mem
// List word RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module oale_mem #(
  parameter int unsigned DEPTH = oale_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/oale_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oale_ctrl
// Request sequencer: walks the list RAM for shifts, reads and searches,
// keeps the word count and holds the result beat.
// ----------------------------------------------------------------------------
module oale_ctrl #(
  parameter int unsigned DEPTH = oale_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  oale_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output oale_pkg::rsp_t out_data_o,
  input  logic [CW-1:0]  cap_i,
  output logic           we_o,
  output logic [AW-1:0]  waddr_o,
  output logic [31:0]    wdata_o,
  output logic           re_o,
  output logic [AW-1:0]  raddr_o,
  input  logic [31:0]    rdata_i
);

  localparam int unsigned CMPW = (CW > 7) ? CW : 7;

  oale_pkg::state_e   state_q, state_d;
  oale_pkg::req_t     req_q, req_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  oale_pkg::status_e  st_q, st_d;
  logic signed [31:0] rv_q, rv_d;
  logic [6:0]         fp_q, fp_d;
  logic               out_valid_q, out_valid_d;
  oale_pkg::rsp_t     out_q, out_d;

  logic [CMPW-1:0] pos_x, cnt_x;
  logic [AW-1:0]   p_a, last_a;
  logic            full, empty, pos_gt, pos_ge, pos_last, hit, out_free;

  assign pos_x    = CMPW'(req_q.position);
  assign cnt_x    = CMPW'(cnt_q);
  assign p_a      = AW'(req_q.position);
  assign last_a   = AW'(cnt_q - 1'b1);
  assign full     = (cnt_q >= cap_i);
  assign empty    = (cnt_q == '0);
  assign pos_gt   = (pos_x > cnt_x);
  assign pos_ge   = (pos_x >= cnt_x);
  assign pos_last = (pos_x == cnt_x - 1'b1);
  assign hit      = (rdata_i == req_q.data_value);
  assign out_free = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == oale_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      oale_pkg::S_IDLE: begin
        if (in_valid_i) state_d = oale_pkg::S_EXEC;
      end
      oale_pkg::S_EXEC: begin
        state_d = oale_pkg::S_FIN;
        case (req_q.mode)
          oale_pkg::MODE_INSERT: begin
            if (!full && !pos_gt) begin
              state_d = pos_ge ? oale_pkg::S_WRV : oale_pkg::S_SHUP;
            end
          end
          oale_pkg::MODE_REMOVE: begin
            if (!empty && !pos_ge && !pos_last) state_d = oale_pkg::S_SHDN;
          end
          oale_pkg::MODE_READ: begin
            if (!empty) state_d = oale_pkg::S_RDWT;
          end
          oale_pkg::MODE_SEARCH: begin
            if (!empty) state_d = oale_pkg::S_SRCH;
          end
          oale_pkg::MODE_REPLACE: begin
            if (!empty && !pos_ge) state_d = oale_pkg::S_WRV;
          end
          default: state_d = oale_pkg::S_FIN;
        endcase
      end
      oale_pkg::S_SHUP: begin
        if (ptr_q == p_a) state_d = oale_pkg::S_WRV;
      end
      oale_pkg::S_SHDN: begin
        if (ptr_q == last_a) state_d = oale_pkg::S_FIN;
      end
      oale_pkg::S_RDWT: state_d = oale_pkg::S_FIN;
      oale_pkg::S_SRCH: begin
        if (hit || ptr_q == last_a) state_d = oale_pkg::S_FIN;
      end
      oale_pkg::S_WRV: state_d = oale_pkg::S_FIN;
      oale_pkg::S_FIN: begin
        if (out_free) state_d = oale_pkg::S_IDLE;
      end
      default: state_d = oale_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    req_d       = req_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    st_d        = st_q;
    rv_d        = rv_q;
    fp_d        = fp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we_o        = 1'b0;
    waddr_o     = '0;
    wdata_o     = '0;
    re_o        = 1'b0;
    raddr_o     = '0;
    case (state_q)
      oale_pkg::S_IDLE: begin
        if (in_valid_i) req_d = in_data_i;
      end
      oale_pkg::S_EXEC: begin
        st_d = oale_pkg::STATUS_OK;
        rv_d = '0;
        fp_d = '0;
        case (req_q.mode)
          oale_pkg::MODE_INSERT: begin
            if (full) begin
              st_d = oale_pkg::STATUS_FULL;
            end else if (pos_gt) begin
              st_d = oale_pkg::STATUS_BADPOS;
            end else if (!pos_ge) begin
              ptr_d   = last_a;
              re_o    = 1'b1;
              raddr_o = last_a;
            end
          end
          oale_pkg::MODE_REMOVE: begin
            if (empty) begin
              st_d = oale_pkg::STATUS_EMPTY;
            end else if (pos_ge) begin
              st_d = oale_pkg::STATUS_BADPOS;
            end else if (pos_last) begin
              cnt_d = cnt_q - 1'b1;
            end else begin
              ptr_d   = AW'(p_a + 1'b1);
              re_o    = 1'b1;
              raddr_o = AW'(p_a + 1'b1);
            end
          end
          oale_pkg::MODE_READ: begin
            if (empty) begin
              st_d = oale_pkg::STATUS_EMPTY;
            end else begin
              re_o    = 1'b1;
              raddr_o = pos_ge ? last_a : p_a;
            end
          end
          oale_pkg::MODE_SEARCH: begin
            if (empty) begin
              st_d = oale_pkg::STATUS_NOTFOUND;
              fp_d = 7'(cnt_q);
            end else begin
              ptr_d   = '0;
              re_o    = 1'b1;
              raddr_o = '0;
            end
          end
          oale_pkg::MODE_REPLACE: begin
            if (empty) begin
              st_d = oale_pkg::STATUS_EMPTY;
            end else if (pos_ge) begin
              st_d = oale_pkg::STATUS_BADPOS;
            end
          end
          default: st_d = oale_pkg::STATUS_OK;
        endcase
      end
      oale_pkg::S_SHUP: begin
        we_o    = 1'b1;
        waddr_o = AW'(ptr_q + 1'b1);
        wdata_o = rdata_i;
        if (ptr_q != p_a) begin
          ptr_d   = AW'(ptr_q - 1'b1);
          re_o    = 1'b1;
          raddr_o = AW'(ptr_q - 1'b1);
        end
      end
      oale_pkg::S_SHDN: begin
        we_o    = 1'b1;
        waddr_o = AW'(ptr_q - 1'b1);
        wdata_o = rdata_i;
        if (ptr_q == last_a) begin
          cnt_d = cnt_q - 1'b1;
        end else begin
          ptr_d   = AW'(ptr_q + 1'b1);
          re_o    = 1'b1;
          raddr_o = AW'(ptr_q + 1'b1);
        end
      end
      oale_pkg::S_RDWT: begin
        rv_d = $signed(rdata_i);
      end
      oale_pkg::S_SRCH: begin
        if (hit) begin
          fp_d = 7'(ptr_q);
        end else if (ptr_q == last_a) begin
          st_d = oale_pkg::STATUS_NOTFOUND;
          fp_d = 7'(cnt_q);
        end else begin
          ptr_d   = AW'(ptr_q + 1'b1);
          re_o    = 1'b1;
          raddr_o = AW'(ptr_q + 1'b1);
        end
      end
      oale_pkg::S_WRV: begin
        we_o    = 1'b1;
        waddr_o = p_a;
        wdata_o = req_q.data_value;
        if (req_q.mode == oale_pkg::MODE_INSERT) cnt_d = cnt_q + 1'b1;
      end
      oale_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.status         = st_q;
          out_d.read_value     = rv_q;
          out_d.found_position = fp_q;
          out_d.entry_count    = 7'(cnt_q);
          out_d.is_empty       = empty;
          out_d.is_full        = full;
        end
      end
      default: out_d = out_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oale_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    ptr_q <= ptr_d;
    st_q  <= st_d;
    rv_q  <= rv_d;
    fp_q  <= fp_d;
    out_q <= out_d;
  end

endmodule

// File: rtl/oale_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oale_checker
// Port-level checks for the ordered array list engine.
// ----------------------------------------------------------------------------
module oale_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input oale_pkg::rsp_t out_data_o
);

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.entry_count == 7'd0)))
    else $error("empty flag disagrees with count");

  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == oale_pkg::STATUS_FULL |-> out_data_o.is_full)
    else $error("full status without full flag");

  a_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_value != 32'sd0
      |-> out_data_o.status == oale_pkg::STATUS_OK)
    else $error("read value on failed request");

endmodule

bind ordered_array_list_engine_top oale_checker u_oale_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
